// ===== hdl/laser_range_frame_parser_macros.svh =====
// Assertion macros shared by the frame parser modules.
`ifndef LASER_RANGE_FRAME_PARSER_MACROS_SVH
`define LASER_RANGE_FRAME_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define LRFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame parser assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LRFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame parser assertion failed");

`else

`define LRFP_ASSERT_NOW(label, ante, cons)
`define LRFP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/lrfp_pkg.sv =====
// Package with the frame format constants, status codes and shared types.
package lrfp_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h80;
    localparam logic [3:0] CHECK_POS   = 4'd10;
    localparam int         DIGIT_COUNT = 5;

    localparam int DIST_W = 17;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CSUM    = 2'd1,
        STATUS_NODIGIT = 2'd2
    } t_status;

    // What the framer hands to the decoder on the checksum byte.
    typedef struct packed {
        logic                            csum_ok;
        logic [DIGIT_COUNT-1:0][7:0]     digits;
    } t_frame;

endpackage

// ===== hdl/lrfp_framer.sv =====
// Header hunt, byte position, running sum and digit store of the frame parser.
`include "laser_range_frame_parser_macros.svh"

module lrfp_framer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_rx_byte,
    output logic           o_last,
    output lrfp_pkg::t_frame o_frame
);
    import lrfp_pkg::*;

    logic       r_in_frame, n_in_frame;
    logic [3:0] r_byte_index, n_byte_index;
    logic [7:0] r_running_sum, n_running_sum;
    logic [DIGIT_COUNT-1:0][7:0] r_digit_store;

    assign o_last = r_in_frame && (r_byte_index >= CHECK_POS);

    assign o_frame.csum_ok = (8'(8'd0 - r_running_sum) == i_rx_byte);
    assign o_frame.digits  = r_digit_store;

    always_comb begin
        n_in_frame    = r_in_frame;
        n_byte_index  = r_byte_index;
        n_running_sum = r_running_sum;
        if (i_accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == HEADER_BYTE) begin
                    n_in_frame    = 1'b1;
                    n_byte_index  = 4'd1;
                    n_running_sum = i_rx_byte;
                end
            end else if (o_last) begin
                n_in_frame    = 1'b0;
                n_byte_index  = 4'd0;
                n_running_sum = 8'd0;
            end else begin
                n_byte_index  = r_byte_index + 4'd1;
                n_running_sum = r_running_sum + i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_byte_index  <= 4'd0;
            r_running_sum <= 8'd0;
        end else begin
            r_in_frame    <= n_in_frame;
            r_byte_index  <= n_byte_index;
            r_running_sum <= n_running_sum;
        end
    end

    // Positions 4, 5, 7, 8 and 9 are kept; the decimal point at 6 is skipped.
    always_ff @(posedge i_clk) begin
        if (i_accept && r_in_frame && !o_last) begin
            case (r_byte_index)
                4'd4:    r_digit_store[0] <= i_rx_byte;
                4'd5:    r_digit_store[1] <= i_rx_byte;
                4'd7:    r_digit_store[2] <= i_rx_byte;
                4'd8:    r_digit_store[3] <= i_rx_byte;
                4'd9:    r_digit_store[4] <= i_rx_byte;
                default: ;
            endcase
        end
    end

    `LRFP_ASSERT_NOW(a_hunt_clear, !r_in_frame, (r_byte_index == 4'd0) && (r_running_sum == 8'd0))
    `LRFP_ASSERT_NOW(a_index_range, r_in_frame, (r_byte_index >= 4'd1) && (r_byte_index <= CHECK_POS))
    `LRFP_ASSERT_NEXT(a_header_start, i_accept && !r_in_frame && (i_rx_byte == HEADER_BYTE),
        r_in_frame && (r_byte_index == 4'd1))

endmodule

// ===== hdl/lrfp_decode.sv =====
// Checksum verdict and leading-digit conversion into a distance and status.
module lrfp_decode (
    input  lrfp_pkg::t_frame               i_frame,
    output logic [lrfp_pkg::DIST_W-1:0]    o_distance_mm,
    output lrfp_pkg::t_status              o_status
);
    import lrfp_pkg::*;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    logic [DIST_W-1:0] acc;
    logic              run;

    // Five short steps of multiply by ten and add, stopping at the first non-digit.
    always_comb begin
        acc = '0;
        run = 1'b1;
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (run && is_digit(i_frame.digits[k])) begin
                acc = DIST_W'(acc * DIST_W'(10)) + DIST_W'(i_frame.digits[k][3:0]);
            end else begin
                run = 1'b0;
            end
        end
    end

    always_comb begin
        if (!i_frame.csum_ok) begin
            o_status      = STATUS_CSUM;
            o_distance_mm = '0;
        end else if (!is_digit(i_frame.digits[0])) begin
            o_status      = STATUS_NODIGIT;
            o_distance_mm = '0;
        end else begin
            o_status      = STATUS_OK;
            o_distance_mm = acc;
        end
    end

endmodule

// ===== hdl/laser_range_frame_parser.sv =====
// Top level of the laser range frame parser with its result register.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_rx_byte[7:0]
//  result    out        o_out_valid / i_out_stall o_distance_mm[16:0], o_frame_status[1:0]
//
// One input item is taken every cycle unless the input stalls; the eleventh byte of a frame yields one
// result item in the next cycle, from the result register.
// Synchronous active-low reset returns the parser to header hunting.
// The input stalls only when a held result is still stalled and the next byte
// would finish another frame; all other bytes keep flowing.
`include "laser_range_frame_parser_macros.svh"

module laser_range_frame_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lrfp_pkg::DIST_W-1:0]  o_distance_mm,
    output logic [1:0]                   o_frame_status
);
    import lrfp_pkg::*;

    logic              in_accept;
    logic              last;
    t_frame            frame;
    logic [DIST_W-1:0] dec_distance;
    t_status           dec_status;
    logic              new_result;
    logic              out_taken;

    logic              r_out_valid;
    logic [DIST_W-1:0] r_distance_mm;
    t_status           r_frame_status;

    assign o_in_stall = last && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign new_result = in_accept && last;
    assign out_taken  = r_out_valid && !i_out_stall;

    lrfp_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_last    (last),
        .o_frame   (frame)
    );

    lrfp_decode u_decode (
        .i_frame       (frame),
        .o_distance_mm (dec_distance),
        .o_status      (dec_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (new_result) begin
            r_out_valid <= 1'b1;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (new_result) begin
            r_distance_mm  <= dec_distance;
            r_frame_status <= dec_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_distance_mm  = r_distance_mm;
    assign o_frame_status = r_frame_status;

    `LRFP_ASSERT_NOW(a_err_zero_dist, o_out_valid && (r_frame_status != STATUS_OK),
        o_distance_mm == '0)
    `LRFP_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall && last)
    `LRFP_ASSERT_NEXT(a_drain, out_taken && !new_result, !o_out_valid)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the laser range frame parser: byte stream in, range results out.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lrfp_pkg::*;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_DOT  = 8'h2E;

    typedef struct {
        logic [DIST_W-1:0] distance;
        t_status           status;
    } t_range_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_rx_byte = 8'h00;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [DIST_W-1:0]   o_distance_mm;
    logic [1:0]          o_frame_status;

    // Parser state as the testbench sees it.
    logic                hunting_done;
    logic [3:0]          frame_pos;
    logic [7:0]          byte_sum;
    logic [7:0]          digit_chars [0:DIGIT_COUNT-1];

    t_range_result       expected_ranges [$];
    logic [7:0]          frame_bytes [0:10];
    bit                  gaps_on = 1'b1;
    int                  bytes_sent = 0;
    int                  mismatch_count = 0;

    laser_range_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_distance_mm  (o_distance_mm),
        .o_frame_status (o_frame_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
    endfunction

    // Advances the parser state by one accepted byte and queues the range it yields, if any.
    task automatic parse_rx_byte(input logic [7:0] b);
        logic [7:0]    want_sum;
        int            distance_acc;
        bit            run;
        t_range_result r;
        if (!hunting_done) begin
            if (b == HEADER_BYTE) begin
                hunting_done = 1'b1;
                frame_pos    = 4'd1;
                byte_sum     = b;
            end
        end else if (frame_pos < CHECK_POS) begin
            case (frame_pos)
                4'd4: digit_chars[0] = b;
                4'd5: digit_chars[1] = b;
                4'd7: digit_chars[2] = b;
                4'd8: digit_chars[3] = b;
                4'd9: digit_chars[4] = b;
                default: ;
            endcase
            byte_sum  = byte_sum + b;
            frame_pos = frame_pos + 4'd1;
        end else begin
            want_sum     = 8'd0 - byte_sum;
            distance_acc = 0;
            if (want_sum != b) begin
                r.status = STATUS_CSUM;
            end else if (!is_digit(digit_chars[0])) begin
                r.status = STATUS_NODIGIT;
            end else begin
                r.status = STATUS_OK;
                run      = 1'b1;
                for (int k = 0; k < DIGIT_COUNT; k++) begin
                    if (run && is_digit(digit_chars[k]))
                        distance_acc = distance_acc * 10 + int'(digit_chars[k] - ASCII_ZERO);
                    else
                        run = 1'b0;
                end
            end
            r.distance = DIST_W'(distance_acc);
            expected_ranges.push_back(r);
            hunting_done = 1'b0;
            frame_pos    = 4'd0;
            byte_sum     = 8'd0;
        end
    endtask

    // Entered and left just after a falling edge.
    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(99) < 35) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        parse_rx_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic fill_frame(input logic [39:0] chars);
        frame_bytes[0] = HEADER_BYTE;
        for (int k = 1; k < 4; k++)
            frame_bytes[k] = 8'($urandom);
        frame_bytes[4] = chars[39:32];
        frame_bytes[5] = chars[31:24];
        frame_bytes[6] = ASCII_DOT;
        frame_bytes[7] = chars[23:16];
        frame_bytes[8] = chars[15:8];
        frame_bytes[9] = chars[7:0];
    endtask

    // Sends the first nbytes of the frame buffer after closing it with its checksum.
    task automatic send_frame(input int nbytes, input bit bad_sum);
        logic [7:0] s;
        s = 8'd0;
        for (int k = 0; k < 10; k++)
            s = s + frame_bytes[k];
        frame_bytes[10] = 8'd0 - s;
        if (bad_sum)
            frame_bytes[10] = frame_bytes[10] ^ 8'($urandom_range(255, 1));
        for (int k = 0; k < nbytes; k++)
            send_byte(frame_bytes[k]);
    endtask

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return ASCII_ZERO + 8'($urandom_range(9));
        if (r < 85)
            return ($urandom_range(1) != 0) ? ASCII_ZERO - 8'd1 : ASCII_NINE + 8'd1;
        return 8'($urandom);
    endfunction

    task automatic test_directed_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h81);
        // Header bytes inside a frame are plain data and do not restart it.
        fill_frame("99999");
        frame_bytes[1] = HEADER_BYTE;
        frame_bytes[2] = 8'h00;
        frame_bytes[3] = 8'hFF;
        send_frame(11, 1'b0);
        fill_frame("0/9:5");
        frame_bytes[6] = HEADER_BYTE;
        send_frame(11, 1'b0);
        fill_frame("12:45");
        send_frame(11, 1'b0);
        fill_frame("-1234");
        send_frame(11, 1'b0);
        fill_frame(":1234");
        send_frame(11, 1'b0);
        fill_frame("54321");
        send_frame(11, 1'b1);
    endtask

    // Mostly well-formed frames, with noise, truncated frames and bad checksums mixed in.
    task automatic random_frames(input int n_bytes);
        int stop_at;
        int r;
        int noise;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            noise = ($urandom_range(99) < 70) ? 0 : $urandom_range(3, 1);
            repeat (noise)
                send_byte(($urandom_range(99) < 5) ? HEADER_BYTE : 8'($urandom));
            fill_frame({random_char(), random_char(), random_char(), random_char(),
                        random_char()});
            if ($urandom_range(99) < 10)
                frame_bytes[6] = 8'($urandom);
            r = $urandom_range(99);
            if (r < 8)
                send_frame($urandom_range(10, 1), 1'b0);
            else
                send_frame(11, r < 22);
        end
    endtask

    task automatic test_back_to_back_frames();
        gaps_on = 1'b0;
        random_frames(300);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_frames();
        random_frames(1550);
    endtask

    always @(negedge i_clk)
        i_out_stall <= gaps_on && ($urandom_range(99) < 35);

    always @(posedge i_clk) begin : check_result
        t_range_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ranges.size() == 0) begin
                $error("result item with none expected: distance_mm %0d frame_status %0d",
                       o_distance_mm, o_frame_status);
                mismatch_count++;
            end else begin
                want = expected_ranges.pop_front();
                if (o_distance_mm !== want.distance) begin
                    $error("distance_mm: expected %0d, actual %0d",
                           want.distance, o_distance_mm);
                    mismatch_count++;
                end
                if (o_frame_status !== want.status) begin
                    $error("frame_status: expected %0d, actual %0d",
                           want.status, o_frame_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        hunting_done = 1'b0;
        frame_pos    = 4'd0;
        byte_sum     = 8'd0;
        for (int k = 0; k < DIGIT_COUNT; k++)
            digit_chars[k] = 8'h00;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_frames();
        test_back_to_back_frames();
        test_random_frames();
        i_in_valid <= 1'b0;
        while (expected_ranges.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
